/* rtl/packet_loss_match_table_macros.svh */
// Assertion macros for the packet loss match table.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef PACKET_LOSS_MATCH_TABLE_MACROS_SVH
`define PACKET_LOSS_MATCH_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PLMT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plmt assertion failed");

`define PLMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plmt assertion failed");

`else

`define PLMT_ASSERT_SAME(label, ante, cons)

`define PLMT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/plmt_pkg.sv */
package plmt_pkg;

  localparam int ID_W      = 16;
  localparam int TIME_W    = 32;
  localparam int KIND_W    = 3;
  localparam int TIMEOUT_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd10;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_MATCH  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERTED  = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_FOUND     = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_LOST      = 3'd4
  } kind_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

/* rtl/plmt_ifs.sv */
interface plmt_in_if import plmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ID_W-1:0]   packet_id;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, opcode, packet_id, now_time, input ready);
  modport sink   (input valid, opcode, packet_id, now_time, output ready);
endinterface

interface plmt_out_if import plmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [ID_W-1:0]   event_id;
  logic              last_event;

  modport source (output valid, event_kind, event_id, last_event, input ready);
  modport sink   (input valid, event_kind, event_id, last_event, output ready);
endinterface

/* rtl/plmt_ram.sv */
module plmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/packet_loss_match_table.sv */
// Packet loss match table. An insert request (opcode 0) appends packet_id and
// now_time to an oldest-first table of DEPTH entries held in one RAM and
// answers with one result (inserted, or rejected when full). A match request
// (opcode 1) walks the live entries from the oldest, one RAM read per cycle
// while no lost report waits, through a single age subtract/compare unit: aged
// entries ahead of the first id match are dropped and reported lost, the match
// is dropped and reported found (else not-found), and survivors are re-packed
// in place behind the read pointer. Either request is held up while a report
// (lost or final) finds the result register full and the result side holds it
// off. in_req.ready is high only while no request is in progress. loss_timeout
// is written through cfg_we/cfg_wdata; the user must write it only while idle,
// as the block itself does not enforce this. An entry is lost when
// now_time - stamp (mod 2^32) exceeds it.
`include "packet_loss_match_table_macros.svh"

module packet_loss_match_table import plmt_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  plmt_in_if.sink              in_req,
  plmt_out_if.source           out_res,
  input  logic                 cfg_we,
  input  logic [TIMEOUT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        kept_r, kept_nxt;
  logic                 found_r, found_nxt;
  logic [TIMEOUT_W-1:0] timeout_r;

  kind_t                kind_r, kind_nxt;
  logic [ID_W-1:0]      pid_r, pid_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  entry_t               ram_wdata, rd_entry;

  logic                 in_acc, can_load, out_load;
  logic                 hit, aged, lost, keep, last_step;
  logic [TIME_W-1:0]    age;

  plmt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign can_load     = !out_valid_r || out_res.ready;

  // shared age unit: one subtract and compare per walked entry
  assign age       = now_r - rd_entry.stamp;
  assign aged      = age > {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_r};
  assign hit       = !found_r && (rd_entry.id == pid_r);
  assign lost      = !found_r && !hit && aged;
  assign keep      = !hit && !lost;
  assign last_step = (CW'(idx_r) + CW'(1)) == count_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    kept_nxt     = kept_r;
    found_nxt    = found_r;
    kind_nxt     = kind_r;
    pid_nxt      = pid_r;
    now_nxt      = now_r;
    ram_we       = 1'b0;
    ram_waddr    = kept_r[AW-1:0];
    ram_wdata    = rd_entry;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    out_load     = 1'b0;
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_last_nxt = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pid_nxt   = in_req.packet_id;
          now_nxt   = in_req.now_time;
          state_nxt = S_FIN;
          if (in_req.opcode == OP_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              kind_nxt = KIND_FULL;
            end else begin
              ram_we          = 1'b1;
              ram_waddr       = count_r[AW-1:0];
              ram_wdata.id    = in_req.packet_id;
              ram_wdata.stamp = in_req.now_time;
              count_nxt       = count_r + CW'(1);
              kind_nxt        = KIND_INSERTED;
            end
          end else begin
            idx_nxt   = '0;
            kept_nxt  = '0;
            found_nxt = 1'b0;
            if (count_r == '0) begin
              kind_nxt = KIND_NOT_FOUND;
            end else begin
              ram_re    = 1'b1;
              state_nxt = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        // a lost report waits for the result register to free up
        if (!lost || can_load) begin
          if (keep) begin
            ram_we   = 1'b1;
            kept_nxt = kept_r + CW'(1);
          end
          if (lost) begin
            out_load     = 1'b1;
            out_kind_nxt = KIND_LOST;
            out_id_nxt   = rd_entry.id;
            out_last_nxt = 1'b0;
          end
          found_nxt = found_r || hit;
          if (last_step) begin
            count_nxt = kept_r + CW'(keep);
            kind_nxt  = (found_r || hit) ? KIND_FOUND : KIND_NOT_FOUND;
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_r + AW'(1);
          end
        end
      end
      S_FIN: begin
        if (can_load) begin
          out_load     = 1'b1;
          out_kind_nxt = kind_r;
          out_id_nxt   = pid_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      kept_r      <= '0;
      found_r     <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      kept_r      <= kept_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    pid_r      <= pid_nxt;
    now_r      <= now_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.event_kind = out_kind_r;
  assign out_res.event_id   = out_id_r;
  assign out_res.last_event = out_last_r;

  `PLMT_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `PLMT_ASSERT_SAME(a_pack_behind_read, state_r == S_WALK, kept_r <= CW'(idx_r))
  `PLMT_ASSERT_NEXT(a_busy_after_accept, in_acc, state_r != S_IDLE)

endmodule

/* verif/packet_loss_match_table_checker.sv */
module packet_loss_match_table_checker import plmt_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  plmt_in_if                   req_ch,
  plmt_out_if                  res_ch,
  input  logic                 cfg_we,
  input  logic [TIMEOUT_W-1:0] cfg_wdata,
  output int                   fail_count,
  output int                   outstanding
);

  typedef struct {
    kind_t           kind;
    logic [ID_W-1:0] id;
    logic            last;
  } table_report_t;

  // oldest first; the table in the block always holds one contiguous run from address 0
  entry_t               live_packets[$];
  table_report_t        due_reports[$];
  logic [TIMEOUT_W-1:0] loss_timeout = TIMEOUT_RST;
  int                   mismatch_total = 0;
  int                   due_total = 0;

  assign fail_count  = mismatch_total;
  assign outstanding = due_total;

  task automatic note_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatch_total++;
  endtask

  task automatic apply_request(input logic op, input logic [ID_W-1:0] pid,
                               input logic [TIME_W-1:0] now);
    entry_t            survivors[$];
    logic              found;
    logic [TIME_W-1:0] age;
    if (op == OP_INSERT) begin
      if (live_packets.size() >= DEPTH) begin
        due_reports.push_back('{KIND_FULL, pid, 1'b1});
      end else begin
        live_packets.push_back('{id: pid, stamp: now});
        due_reports.push_back('{KIND_INSERTED, pid, 1'b1});
      end
    end else begin
      found = 1'b0;
      foreach (live_packets[k]) begin
        age = now - live_packets[k].stamp;
        if (found) begin
          survivors.push_back(live_packets[k]);
        end else if (live_packets[k].id == pid) begin
          found = 1'b1;
        end else if (age > {16'b0, loss_timeout}) begin
          due_reports.push_back('{KIND_LOST, live_packets[k].id, 1'b0});
        end else begin
          survivors.push_back(live_packets[k]);
        end
      end
      live_packets = survivors;
      due_reports.push_back('{found ? KIND_FOUND : KIND_NOT_FOUND, pid, 1'b1});
    end
  endtask

  task automatic check_report();
    table_report_t want;
    if (due_reports.size() == 0) begin
      note_mismatch($sformatf("result kind %0d id %h with none pending",
                              res_ch.event_kind, res_ch.event_id));
      return;
    end
    want = due_reports.pop_front();
    if (res_ch.event_kind !== want.kind)
      note_mismatch($sformatf("event_kind %0d, want %0d (id %h)",
                              res_ch.event_kind, want.kind, want.id));
    if (res_ch.event_id !== want.id)
      note_mismatch($sformatf("event_id %h, want %h", res_ch.event_id, want.id));
    if (res_ch.last_event !== want.last)
      note_mismatch($sformatf("last_event %b, want %b (id %h)",
                              res_ch.last_event, want.last, want.id));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      live_packets.delete();
      due_reports.delete();
      loss_timeout = TIMEOUT_RST;
    end else begin
      // results first: nothing requested at this edge can leave at this edge
      if (res_ch.valid && res_ch.ready) check_report();
      if (req_ch.valid && req_ch.ready)
        apply_request(req_ch.opcode, req_ch.packet_id, req_ch.now_time);
      if (cfg_we) loss_timeout = cfg_wdata;
    end
    due_total <= due_reports.size();
  end

endmodule

/* verif/packet_loss_match_table_tb.sv */
module packet_loss_match_table_tb;
  import plmt_pkg::*;

  localparam int TABLE_DEPTH  = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE_TICKS = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [TIMEOUT_W-1:0] cfg_wdata = '0;
  logic                 idle_on = 1'b1;
  int                   hold_asked = 0;
  int                   hold_served = 0;
  int                   cycle_count = 0;
  int                   fail_count;
  int                   outstanding;
  logic [TIME_W-1:0]    t_now = '0;
  logic [ID_W-1:0]      recent_ids[$];

  plmt_in_if  req_ch();
  plmt_out_if res_ch();

  packet_loss_match_table #(.DEPTH(TABLE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  packet_loss_match_table_checker #(.DEPTH(TABLE_DEPTH)) table_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ch     (req_ch),
    .res_ch     (res_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random back-pressure, plus long hold-offs on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_served + 1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ch.ready <= !(idle_on && $urandom_range(99) < 26);
      end
    end
  end

  // valid is left high after acceptance; it drops only on a gap or a drain
  task automatic offer_request(input logic op, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] stamp);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(99) < 26) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.opcode    <= op;
    req_ch.packet_id <= id;
    req_ch.now_time  <= stamp;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic settle_table();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic set_loss_timeout(input logic [TIMEOUT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly insert/match pairs on live ids, with some duplicates and noise
  task automatic run_traffic(input int count, input int step_max);
    logic            op;
    logic [ID_W-1:0] id;
    int              pick;
    repeat (count) begin
      t_now = t_now + $urandom_range(0, step_max);
      if ($urandom_range(99) < 10) begin
        offer_request(1'($urandom_range(1)), ID_W'($urandom()), $urandom());
      end else if ($urandom_range(99) < 58) begin
        if (recent_ids.size() != 0 && $urandom_range(99) < 10)
          id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        else
          id = ID_W'($urandom());
        recent_ids.push_back(id);
        if (recent_ids.size() > 40) void'(recent_ids.pop_front());
        offer_request(OP_INSERT, id, t_now);
      end else begin
        if (recent_ids.size() != 0 && $urandom_range(99) < 75) begin
          pick = $urandom_range(0, recent_ids.size() - 1);
          id = recent_ids[pick];
          recent_ids.delete(pick);
        end else begin
          id = ID_W'($urandom());
        end
        op = OP_MATCH;
        offer_request(op, id, t_now);
      end
    end
  endtask

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.opcode    = OP_INSERT;
    req_ch.packet_id = '0;
    req_ch.now_time  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset timeout of 10
    offer_request(OP_MATCH,  16'hFFFF, 32'd0);          // empty table
    offer_request(OP_INSERT, 16'h0000, 32'd0);
    offer_request(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    offer_request(OP_INSERT, 16'h1234, 32'd5);
    offer_request(OP_INSERT, 16'h1234, 32'd6);          // same id twice
    offer_request(OP_MATCH,  16'h1234, 32'd12);         // two lost, wrapped age
    offer_request(OP_MATCH,  16'h1234, 32'd100);        // aged but matching
    offer_request(OP_INSERT, 16'hAAAA, 32'd100);
    offer_request(OP_INSERT, 16'h5555, 32'd101);
    offer_request(OP_MATCH,  16'h7777, 32'd105);        // miss, nothing aged
    offer_request(OP_MATCH,  16'h7777, 32'd200);        // miss, all aged
    offer_request(OP_INSERT, 16'h0001, 32'd300);
    offer_request(OP_INSERT, 16'h0002, 32'd300);
    offer_request(OP_INSERT, 16'h0003, 32'd300);
    offer_request(OP_MATCH,  16'h0002, 32'd400);        // aged entry after hit stays
    offer_request(OP_MATCH,  16'h0003, 32'd400);
    settle_table();

    // fill to full while results are held off, then drop everything at once
    set_loss_timeout(16'hFFFF);
    hold_asked <= hold_asked + 1;
    t_now = 32'h0000_1000;
    for (int k = 0; k <= TABLE_DEPTH; k++)
      offer_request(OP_INSERT, ID_W'(16'h8000 + k), t_now);
    offer_request(OP_MATCH, 16'h7FFF, t_now + 32'd70000);
    settle_table();

    t_now = 32'hFFFF_0000;
    run_traffic(35, 12000);
    settle_table();

    set_loss_timeout(16'd0);
    run_traffic(35, 1);
    settle_table();

    set_loss_timeout(16'd40);
    idle_on <= 1'b0;
    run_traffic(28, 8);
    idle_on <= 1'b1;
    run_traffic(12, 8);
    settle_table();

    if (fail_count == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/plmt_pkg.sv
rtl/plmt_ifs.sv
rtl/plmt_ram.sv
rtl/packet_loss_match_table.sv
verif/packet_loss_match_table_checker.sv
verif/packet_loss_match_table_tb.sv
